// ===== src/qth_pkg.sv =====
// ----------------------------------------------------------------------------
// qth_pkg: shared constants and types for the quaternion heading block
// Angle units, the arctangent step table and the quadrant side-band struct.
// ----------------------------------------------------------------------------
package qth_pkg;

  localparam int OFF_W     = 15;     // heading / offset width, 1/64 degree units
  localparam int FULL_TURN = 23040;  // 360 degrees in 1/64 degree units
  localparam int KEEP_W    = 30;     // magnitude bits entering the angle cells
  localparam int CX_W      = 33;     // angle cell x/y width, signed
  localparam int ANG_W     = 26;     // angle width, signed, 2^-16 degree units
  localparam int TAB_N     = 24;
  localparam int RND_SH    = 10;     // 2^-16 deg -> 1/64 deg
  localparam int RND_BIAS  = 512;

  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;

  // atan(2^-n) in 2^-16 degree units, rounded to nearest
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_N] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic zero;   // x and y both zero
    logic x_neg;
    logic y_neg;
  } qth_side_t;

endpackage

// ===== src/qth_ifs.sv =====
// ----------------------------------------------------------------------------
// qth_ifs: valid/ready channels of the quaternion heading block
// Quaternion word in, heading word out.
// ----------------------------------------------------------------------------
interface qth_in_if #(parameter int COMPONENT_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] quat_i;
  logic signed [COMPONENT_WIDTH-1:0] quat_j;
  logic signed [COMPONENT_WIDTH-1:0] quat_k;
  logic signed [COMPONENT_WIDTH-1:0] quat_real;

  modport source (output valid, output quat_i, output quat_j, output quat_k,
                  output quat_real, input ready);
  modport sink   (input valid, input quat_i, input quat_j, input quat_k,
                  input quat_real, output ready);
endinterface

interface qth_out_if;
  logic                       valid;
  logic                       ready;
  logic [qth_pkg::OFF_W-1:0]  heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

// ===== src/qth_vec.sv =====
// ----------------------------------------------------------------------------
// qth_vec: yaw vector front end
// Three stages: component products, x/y sums, magnitudes and quadrant flags.
// ----------------------------------------------------------------------------
module qth_vec #(
  parameter int CW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [CW-1:0]       qi,
  input  logic signed [CW-1:0]       qj,
  input  logic signed [CW-1:0]       qk,
  input  logic signed [CW-1:0]       qr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*CW:0]              ax,
  output logic [2*CW:0]              ay,
  output qth_pkg::qth_side_t         side
);
  import qth_pkg::*;

  localparam int PW  = 2*CW;
  localparam int XW  = 2*CW + 2;
  localparam int AW  = 2*CW + 1;
  localparam int DSH = (CW > 31) ? 2 : 0;   // wide parts: products / 4

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [PW-1:0] qi_e, qj_e, qk_e, qr_e;
  logic signed [PW-1:0] rr_r, ii_r, jj_r, kk_r, ij_r, rk_r;
  logic signed [PW-1:0] rr_nxt, ii_nxt, jj_nxt, kk_nxt, ij_nxt, rk_nxt;
  logic signed [PW-1:0] ij_s, rk_s;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [XW-1:0]        xa, ya;
  logic [AW-1:0]        ax_r, ay_r, ax_nxt, ay_nxt;
  qth_side_t            side_r, side_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // stage 1: products
  always_comb begin
    qi_e   = PW'(qi);
    qj_e   = PW'(qj);
    qk_e   = PW'(qk);
    qr_e   = PW'(qr);
    rr_nxt = qr_e * qr_e;
    ii_nxt = qi_e * qi_e;
    jj_nxt = qj_e * qj_e;
    kk_nxt = qk_e * qk_e;
    ij_nxt = qi_e * qj_e;
    rk_nxt = qr_e * qk_e;
  end

  // stage 2: x = r^2 + i^2 - j^2 - k^2, y = 2(ij + rk); cross terms truncate to zero
  always_comb begin
    ij_s  = ij_r[PW-1] ? -((-ij_r) >>> DSH) : (ij_r >>> DSH);
    rk_s  = rk_r[PW-1] ? -((-rk_r) >>> DSH) : (rk_r >>> DSH);
    x_nxt = XW'(rr_r >>> DSH) + XW'(ii_r >>> DSH)
          - XW'(jj_r >>> DSH) - XW'(kk_r >>> DSH);
    y_nxt = (XW'(ij_s) + XW'(rk_s)) <<< 1;
  end

  // stage 3: magnitudes and quadrant
  always_comb begin
    xa             = x_r[XW-1] ? XW'(-x_r) : XW'(x_r);
    ya             = y_r[XW-1] ? XW'(-y_r) : XW'(y_r);
    ax_nxt         = xa[AW-1:0];
    ay_nxt         = ya[AW-1:0];
    side_nxt.zero  = (x_r == '0) && (y_r == '0);
    side_nxt.x_neg = x_r[XW-1];
    side_nxt.y_neg = y_r[XW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rr_r <= rr_nxt;
      ii_r <= ii_nxt;
      jj_r <= jj_nxt;
      kk_r <= kk_nxt;
      ij_r <= ij_nxt;
      rk_r <= rk_nxt;
    end
    if (en2) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    if (en3) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v3_r;
  assign ax        = ax_r;
  assign ay        = ay_r;
  assign side      = side_r;

endmodule

// ===== src/qth_norm_cell.sv =====
// ----------------------------------------------------------------------------
// qth_norm_cell: one step of the magnitude normalizer
// Shifts both magnitudes left by SH when the top SH bits of both are clear.
// ----------------------------------------------------------------------------
module qth_norm_cell #(
  parameter int NW = 33,
  parameter int SH = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                v_in,
  output logic                en,
  input  logic [NW-1:0]       ax_in,
  input  logic [NW-1:0]       ay_in,
  input  qth_pkg::qth_side_t  side_in,
  input  logic                en_dn,
  output logic                v_r,
  output logic [NW-1:0]       ax_r,
  output logic [NW-1:0]       ay_r,
  output qth_pkg::qth_side_t  side_r
);

  logic [NW-1:0] m;
  logic [NW-1:0] ax_nxt, ay_nxt;

  assign en = !v_r || en_dn;

  always_comb begin
    m = ax_in | ay_in;
    if (m[NW-1 -: SH] == '0) begin
      ax_nxt = ax_in << SH;
      ay_nxt = ay_in << SH;
    end else begin
      ax_nxt = ax_in;
      ay_nxt = ay_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      side_r <= side_in;
    end
  end

endmodule

// ===== src/qth_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// qth_cordic_cell: one vectoring rotation of the angle chain
// Rotates (x, y) toward the x axis by atan(2^-STEP) and books the angle.
// ----------------------------------------------------------------------------
module qth_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                v_in,
  output logic                                en,
  input  logic signed [qth_pkg::CX_W-1:0]     cx_in,
  input  logic signed [qth_pkg::CX_W-1:0]     cy_in,
  input  logic signed [qth_pkg::ANG_W-1:0]    z_in,
  input  qth_pkg::qth_side_t                  side_in,
  input  logic                                en_dn,
  output logic                                v_r,
  output logic signed [qth_pkg::CX_W-1:0]     cx_r,
  output logic signed [qth_pkg::CX_W-1:0]     cy_r,
  output logic signed [qth_pkg::ANG_W-1:0]    z_r,
  output qth_pkg::qth_side_t                  side_r
);
  import qth_pkg::*;

  logic signed [CX_W-1:0]  sx, sy, cx_nxt, cy_nxt;
  logic signed [ANG_W-1:0] z_nxt;

  assign en = !v_r || en_dn;

  // arithmetic shifts floor negative values
  always_comb begin
    sx = cx_in >>> STEP;
    sy = cy_in >>> STEP;
    if (!cy_in[CX_W-1]) begin
      cx_nxt = cx_in + sy;
      cy_nxt = cy_in - sx;
      z_nxt  = z_in + ATAN_TAB[STEP];
    end else begin
      cx_nxt = cx_in - sy;
      cy_nxt = cy_in + sx;
      z_nxt  = z_in - ATAN_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      z_r    <= z_nxt;
      side_r <= side_in;
    end
  end

endmodule

// ===== src/quaternion_to_heading_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_heading_top: orientation quaternion to compass heading
// Yaw from a unit quaternion, offset-corrected, in 1/64 degree units.
// ----------------------------------------------------------------------------
// One quaternion word (i, j, k, real, signed Q14) goes in, one heading word
// comes out, in 1/64 degree (0 .. 23039) after subtracting the configured
// heading offset and wrapping into one turn. A new word is taken every clock
// unless the pipe is full behind a held output. Each word passes through the
// product/sum front end, the normalizer cells, the chain of angle cells and
// stages A and B. Each stage holds its word while the next one is full and
// stalled, so empty stages keep filling when the output is held.
// The offset may only be rewritten while the pipe is empty.
module quaternion_to_heading_top #(
  parameter int COMPONENT_WIDTH  = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [qth_pkg::OFF_W-1:0]     cfg_wdata,
  qth_in_if.sink                        in_w,
  qth_out_if.source                     out_w
);
  import qth_pkg::*;

  localparam int AW = 2*COMPONENT_WIDTH + 1;        // magnitude width
  localparam int NW = (AW > KEEP_W) ? AW : KEEP_W;  // normalizer width
  localparam int NS = $clog2(NW);                   // normalizer cells
  localparam int IT = ANGLE_ITERATIONS;

  // --------------------------------------------------------------------------
  // Heading offset, stored already reduced to one turn
  // --------------------------------------------------------------------------
  logic [OFF_W-1:0] offm_r, offm_nxt;

  always_comb begin
    if (cfg_wdata >= OFF_W'(FULL_TURN)) begin
      offm_nxt = cfg_wdata - OFF_W'(FULL_TURN);
    end else begin
      offm_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offm_r <= '0;
    end else if (cfg_we) begin
      offm_r <= offm_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Front end: products, x/y, magnitudes
  // --------------------------------------------------------------------------
  logic          vec_v;
  logic [AW-1:0] vec_ax, vec_ay;
  qth_side_t     vec_side;

  logic          nv    [NS+1];
  logic          nen   [NS+1];
  logic [NW-1:0] nax   [NS+1];
  logic [NW-1:0] nay   [NS+1];
  qth_side_t     nside [NS+1];

  qth_vec #(.CW(COMPONENT_WIDTH)) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_w.valid),
    .in_ready  (in_w.ready),
    .qi        (in_w.quat_i),
    .qj        (in_w.quat_j),
    .qk        (in_w.quat_k),
    .qr        (in_w.quat_real),
    .out_valid (vec_v),
    .out_ready (nen[0]),
    .ax        (vec_ax),
    .ay        (vec_ay),
    .side      (vec_side)
  );

  assign nv[0]    = vec_v;
  assign nax[0]   = NW'(vec_ax);
  assign nay[0]   = NW'(vec_ay);
  assign nside[0] = vec_side;

  // --------------------------------------------------------------------------
  // Normalizer: binary search of the common left shift, widest step first,
  // so that the larger magnitude ends with its top bit at NW-1
  // --------------------------------------------------------------------------
  for (genvar s = 0; s < NS; s++) begin : g_norm
    qth_norm_cell #(.NW(NW), .SH(1 << (NS - 1 - s))) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (nv[s]),
      .en      (nen[s]),
      .ax_in   (nax[s]),
      .ay_in   (nay[s]),
      .side_in (nside[s]),
      .en_dn   (nen[s+1]),
      .v_r     (nv[s+1]),
      .ax_r    (nax[s+1]),
      .ay_r    (nay[s+1]),
      .side_r  (nside[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Angle chain: top KEEP_W bits of the normalized pair feed the cells
  // (a truncating right shift by NW-KEEP_W bits, after the left shift that the magnitude needs)
  // --------------------------------------------------------------------------
  logic                    cv    [IT+1];
  logic                    cen   [IT+1];
  logic signed [CX_W-1:0]  cx    [IT+1];
  logic signed [CX_W-1:0]  cy    [IT+1];
  logic signed [ANG_W-1:0] cz    [IT+1];
  qth_side_t               cside [IT+1];

  assign cv[0]    = nv[NS];
  assign nen[NS]  = cen[0];
  assign cx[0]    = CX_W'(nax[NS][NW-1 -: KEEP_W]);
  assign cy[0]    = CX_W'(nay[NS][NW-1 -: KEEP_W]);
  assign cz[0]    = '0;
  assign cside[0] = nside[NS];

  for (genvar n = 0; n < IT; n++) begin : g_angle
    qth_cordic_cell #(.STEP(n)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v_in    (cv[n]),
      .en      (cen[n]),
      .cx_in   (cx[n]),
      .cy_in   (cy[n]),
      .z_in    (cz[n]),
      .side_in (cside[n]),
      .en_dn   (cen[n+1]),
      .v_r     (cv[n+1]),
      .cx_r    (cx[n+1]),
      .cy_r    (cy[n+1]),
      .z_r     (cz[n+1]),
      .side_r  (cside[n+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage A: clamp to the first quadrant, unfold, round to 1/64 degree
  // Stage B: subtract the offset, wrap, output register
  // --------------------------------------------------------------------------
  logic                    va_r, vb_r;
  logic                    ena, enb;
  logic signed [ANG_W-1:0] zc, ang, ang_rnd;
  logic [OFF_W-1:0]        h_rnd;
  logic [OFF_W-1:0]        ha_r, ha_nxt;
  logic [OFF_W:0]          diff;
  logic [OFF_W-1:0]        hb_r, hb_nxt;

  assign enb      = !vb_r || out_w.ready;
  assign ena      = !va_r || enb;
  assign cen[IT]  = ena;

  always_comb begin
    zc = cz[IT];
    if (zc[ANG_W-1]) begin
      zc = '0;
    end else if (zc > DEG90) begin
      zc = DEG90;
    end
    case ({cside[IT].y_neg, cside[IT].x_neg})
      2'b00:   ang = zc;
      2'b01:   ang = DEG180 - zc;
      2'b10:   ang = DEG360 - zc;
      default: ang = DEG180 + zc;
    endcase
    ang_rnd = ang + ANG_W'(RND_BIAS);
    h_rnd   = ang_rnd[ANG_W-2:RND_SH];
    // a full turn after rounding folds back to zero
    if (cside[IT].zero || (h_rnd >= OFF_W'(FULL_TURN))) begin
      ha_nxt = '0;
    end else begin
      ha_nxt = h_rnd;
    end
  end

  always_comb begin
    diff = {1'b0, ha_r} - {1'b0, offm_r};
    if (diff[OFF_W]) begin
      diff = diff + (OFF_W+1)'(FULL_TURN);
    end
    hb_nxt = diff[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ena) va_r <= cv[IT];
      if (enb) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) ha_r <= ha_nxt;
    if (enb) hb_r <= hb_nxt;
  end

  assign out_w.valid   = vb_r;
  assign out_w.heading = hb_r;

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_w.valid |-> (out_w.heading < OFF_W'(FULL_TURN)))
    else $error("heading word outside one turn");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_w.ready |-> in_w.ready)
    else $error("input stalled while output side is ready");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_w.valid && out_w.ready && !va_r) |=> !out_w.valid)
    else $error("heading word repeated after hand-off");
`endif

endmodule
